@@ rtl/hni_pkg.sv @@
// hni_pkg: shared types, opcode constants, the decode function and the hazard
// nop-count function for the hazard nop inserter; no dependencies
package hni_pkg;

	localparam logic [6:0] OpAlu    = 7'b0110011;
	localparam logic [6:0] OpImm    = 7'b0010011;
	localparam logic [6:0] OpSys    = 7'b1110011;
	localparam logic [6:0] OpLoad   = 7'b0000011;
	localparam logic [6:0] OpStore  = 7'b0100011;
	localparam logic [6:0] OpBranch = 7'b1100011;
	localparam logic [6:0] OpJal    = 7'b1101111;
	localparam logic [6:0] OpLui    = 7'b0110111;
	localparam logic [6:0] OpAuipc  = 7'b0010111;
	localparam logic [31:0] NopWord = 32'h0000_0013;
	localparam logic [4:0] RegZero  = 5'b00000;

	// one emission job: an instruction, its trailing nop count, end-of-run mark
	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  nops;
		logic        last;
	} hni_job_t;

	// decoded register fields and opcode class
	typedef struct packed {
		logic       is_alu;
		logic       is_imm;
		logic       is_load;
		logic       is_store;
		logic       is_branch;
		logic       hrd;
		logic       hrs1;
		logic       hrs2;
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
	} hni_dec_t;

	function automatic hni_dec_t hni_decode(input logic exists, input logic [31:0] w);
		hni_dec_t d;
		d = '0;
		d.rd  = w[11:7];
		d.rs1 = w[19:15];
		d.rs2 = w[24:20];
		if (exists) begin
			unique case (w[6:0])
				OpAlu: begin
					d.is_alu = 1'b1;
					d.hrd = 1'b1; d.hrs1 = 1'b1; d.hrs2 = 1'b1;
				end
				OpImm, OpSys: begin
					d.is_imm = 1'b1;
					d.hrd = 1'b1; d.hrs1 = 1'b1;
				end
				OpLoad: begin
					d.is_load = 1'b1;
					d.hrd = 1'b1; d.hrs1 = 1'b1;
				end
				OpStore: begin
					d.is_store = 1'b1;
					d.hrs1 = 1'b1; d.hrs2 = 1'b1;
				end
				OpBranch: begin
					d.is_branch = 1'b1;
					d.hrs1 = 1'b1; d.hrs2 = 1'b1;
				end
				OpJal, OpLui, OpAuipc: begin
					d.hrd = 1'b1;
				end
				default: begin
				end
			endcase
		end
		return d;
	endfunction

	// nops after current c, given next n and second successor s
	function automatic logic [1:0] hni_nop_count(input hni_dec_t c, input hni_dec_t n,
		input hni_dec_t s);
		logic       nh;
		logic       n1, n2, s1, s2;
		logic [1:0] k;
		logic       ld;
		nh = n.hrd && ((s.hrs1 && n.rd == s.rs1) || (s.hrs2 && n.rd == s.rs2));
		n1 = n.hrs1 && c.rd == n.rs1;
		n2 = n.hrs2 && c.rd == n.rs2;
		s1 = s.hrs1 && c.rd == s.rs1;
		s2 = s.hrs2 && c.rd == s.rs2;
		k = 2'd0;
		if (c.hrd && c.rd != RegZero) begin
			if (n.is_imm) begin
				if (n1)
					k = 2'd2;
				else if (!nh && s1)
					k = 2'd1;
			end else begin
				if (n1 || n2)
					k = 2'd2;
				else if (!nh && (s1 || s2))
					k = 2'd1;
			end
		end
		// load-use adds one more
		ld = 1'b0;
		if (c.is_load) begin
			if (n.is_imm || n.is_load)
				ld = c.rd == n.rs1;
			else if (n.is_branch || n.is_store || n.is_alu)
				ld = c.rd == n.rs1 || c.rd == n.rs2;
		end
		return k + {1'b0, ld};
	endfunction

endpackage

@@ rtl/hni_if.sv @@
// hni_if: valid/ready stream interfaces for instruction input and result output
// no dependencies
interface hni_instr_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;
	logic        end_of_program;

	modport source(output valid, instr_word, end_of_program, input ready);
	modport sink(input valid, instr_word, end_of_program, output ready);
endinterface

interface hni_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_word;
	logic        is_inserted_nop;
	logic        last_of_run;

	modport source(output valid, out_word, is_inserted_nop, last_of_run, input ready);
	modport sink(input valid, out_word, is_inserted_nop, last_of_run, output ready);
endinterface

@@ rtl/hni_front.sv @@
// hni_front: lookahead window, hazard classification and job generation
// depends on hni_pkg and hni_instr_if
module hni_front
	import hni_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	hni_instr_if.sink     instr,
	output logic          push_valid,
	input  logic          push_ready,
	output hni_job_t      push_job
);

	logic [31:0] win0_q, win1_q, win2_q;
	logic [1:0]  fill_q;
	logic        flush_q;
	logic        acc;
	logic        eop;
	logic        shift_push;
	logic [31:0] s_word;
	logic        n_exists, s_exists;
	hni_dec_t    dc, dn, ds;

	assign eop = instr.end_of_program;
	assign instr.ready = !flush_q && push_ready;
	assign acc = instr.valid && instr.ready;

	// steady push: full window and a non-final word arriving
	assign shift_push = acc && !eop && fill_q == 2'd2;

	// successor selection for the job at the head of the window
	always_comb begin
		if (flush_q) begin
			s_word   = win2_q;
			n_exists = fill_q > 2'd1;
			s_exists = fill_q > 2'd2;
		end else begin
			s_word   = instr.instr_word;
			n_exists = 1'b1;
			s_exists = 1'b1;
		end
	end

	// classify current against its two successors
	always_comb begin
		dc = hni_decode(1'b1, win0_q);
		dn = hni_decode(n_exists, win1_q);
		ds = hni_decode(s_exists, s_word);
		push_job.word = win0_q;
		push_job.nops = hni_nop_count(dc, dn, ds);
		push_job.last = flush_q ? (fill_q == 2'd1) : 1'b1;
	end

	assign push_valid = flush_q || shift_push;

	// control: fill count and flush sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= 2'd0;
			flush_q <= 1'b0;
		end else if (flush_q) begin
			if (push_ready) begin
				fill_q <= fill_q - 2'd1;
				if (fill_q == 2'd1)
					flush_q <= 1'b0;
			end
		end else if (acc) begin
			if (eop) begin
				fill_q  <= fill_q + 2'd1;
				flush_q <= 1'b1;
			end else if (fill_q != 2'd2) begin
				fill_q <= fill_q + 2'd1;
			end
		end
	end

	// window words
	always_ff @(posedge clk) begin
		if (flush_q) begin
			if (push_ready) begin
				win0_q <= win1_q;
				win1_q <= win2_q;
			end
		end else if (acc) begin
			if (shift_push) begin
				win0_q <= win1_q;
				win1_q <= instr.instr_word;
			end else begin
				case (fill_q)
					2'd0:    win0_q <= instr.instr_word;
					2'd1:    win1_q <= instr.instr_word;
					default: win2_q <= instr.instr_word;
				endcase
			end
		end
	end

endmodule

@@ rtl/hni_fifo.sv @@
// hni_fifo: small job queue between classification and emission
// depends on hni_pkg
module hni_fifo
	import hni_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  hni_job_t push_job,
	output logic     pop_valid,
	input  logic     pop_ready,
	output hni_job_t pop_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
	localparam logic [CW-1:0] Full    = CW'(DEPTH);

	hni_job_t      mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = count_q != Full;
	assign pop_valid  = count_q != '0;
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

@@ rtl/hni_back.sv @@
// hni_back: expands each job into the instruction beat and its nop beats
// depends on hni_pkg and hni_result_if
module hni_back
	import hni_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  hni_job_t      pop_job,
	hni_result_if.source  result
);

	logic        busy_q;
	logic [31:0] word_q;
	logic [1:0]  nops_q;
	logic        last_q;
	logic        instr_done_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic        out_nop_q;
	logic        out_last_q;
	logic        beat_final;
	logic        load_out;
	logic        adv;

	assign beat_final = instr_done_q ? (nops_q == 2'd1) : (nops_q == 2'd0);
	assign load_out   = !out_valid_q || result.ready;
	assign adv        = busy_q && load_out;
	assign pop_ready  = !busy_q || (adv && beat_final);

	assign result.valid           = out_valid_q;
	assign result.out_word        = out_word_q;
	assign result.is_inserted_nop = out_nop_q;
	assign result.last_of_run     = out_last_q;

	// job sequencing and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			instr_done_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= adv;
			if (pop_ready && pop_valid) begin
				busy_q       <= 1'b1;
				instr_done_q <= 1'b0;
			end else if (adv) begin
				if (beat_final)
					busy_q <= 1'b0;
				else
					instr_done_q <= 1'b1;
			end
		end
	end

	// job payload and output register
	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			word_q <= pop_job.word;
			nops_q <= pop_job.nops;
			last_q <= pop_job.last;
		end else if (adv && !beat_final && instr_done_q) begin
			nops_q <= nops_q - 2'd1;
		end
		if (adv) begin
			out_word_q <= instr_done_q ? NopWord : word_q;
			out_nop_q  <= instr_done_q;
			out_last_q <= last_q && beat_final;
		end
	end

endmodule

@@ rtl/riscv_hazard_nop_inserter_unit.sv @@
// riscv_hazard_nop_inserter_unit: top level of the data-hazard nop inserter
// depends on hni_pkg, hni_if, hni_front, hni_fifo, hni_back
//
//   port    dir   beat contents
//   instr   in    instr_word[31:0], end_of_program
//   result  out   out_word[31:0], is_inserted_nop, last_of_run
//
// the front takes one instruction beat per cycle while the queue has room and no flush
// runs; an end-of-program beat then writes one job per held word (up to three) into
// the queue; the back sends one result beat per cycle while the result port is ready,
// so an instruction gives 1 to 4 output beats (itself plus its nops); that output port
// sets the rate; the queue lets the front keep accepting while the back drains stalled
// results; reset clears the window count, queue and output valid; no clearing pass
module riscv_hazard_nop_inserter_unit
	import hni_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	hni_instr_if.sink     instr,
	hni_result_if.source  result
);

	logic     push_valid, push_ready;
	logic     pop_valid, pop_ready;
	hni_job_t push_job, pop_job;

	hni_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.instr      (instr),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	hni_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	hni_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.result    (result)
	);

endmodule

@@ dv/riscv_hazard_nop_inserter_unit_checker.sv @@
// riscv_hazard_nop_inserter_unit_checker: watches the instruction and result channels,
// predicts the emitted word stream with nop insertion and compares it beat by beat
// depends on hni_pkg (opcodes, nop word) and hni_if (channel interfaces)
module riscv_hazard_nop_inserter_unit_checker
	import hni_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	hni_instr_if  instr,
	hni_result_if result,
	output int    mismatches,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] word;
		logic        nop;
		logic        last;
	} out_beat_t;

	out_beat_t   expected_beats[$];
	logic [31:0] held_words [2];
	int          held_count;

	// presence of {rd, rs1, rs2} by opcode class
	function automatic logic [2:0] reg_fields(input logic [6:0] op);
		case (op)
			OpAlu:                  return 3'b111;
			OpImm, OpSys, OpLoad:   return 3'b110;
			OpStore, OpBranch:      return 3'b011;
			OpJal, OpLui, OpAuipc:  return 3'b100;
			default:                return 3'b000;
		endcase
	endfunction

	// nops that follow cur, judged against its next word and the one after
	function automatic int hazard_nop_count(input logic [31:0] cur, input logic nxt_ok,
		input logic [31:0] nxt, input logic sec_ok, input logic [31:0] sec);
		logic [2:0] pc, pn, ps;
		logic [4:0] rd;
		logic       nxt_imm, nh, n1, n2, s1, s2;
		int         k;
		pc = reg_fields(cur[6:0]);
		pn = nxt_ok ? reg_fields(nxt[6:0]) : 3'b000;
		ps = sec_ok ? reg_fields(sec[6:0]) : 3'b000;
		rd = cur[11:7];
		nxt_imm = nxt_ok && (nxt[6:0] == OpImm || nxt[6:0] == OpSys);
		// next word's own write already covers the second successor
		nh = pn[2] && ((ps[1] && nxt[11:7] == sec[19:15]) ||
			(ps[0] && nxt[11:7] == sec[24:20]));
		n1 = pn[1] && rd == nxt[19:15];
		n2 = pn[0] && rd == nxt[24:20];
		s1 = ps[1] && rd == sec[19:15];
		s2 = ps[0] && rd == sec[24:20];
		k = 0;
		if (pc[2] && rd != RegZero) begin
			if (nxt_imm)
				k = n1 ? 2 : (!nh && s1) ? 1 : 0;
			else
				k = (n1 || n2) ? 2 : (!nh && (s1 || s2)) ? 1 : 0;
		end
		// load-use adds one, x0 destination included
		if (cur[6:0] == OpLoad && nxt_ok) begin
			if (nxt_imm || nxt[6:0] == OpLoad) begin
				if (n1)
					k++;
			end else if (nxt[6:0] == OpBranch || nxt[6:0] == OpStore || nxt[6:0] == OpAlu) begin
				if (n1 || n2)
					k++;
			end
		end
		return k;
	endfunction

	// queue one instruction and its trailing nops
	task automatic push_instr_beats(input logic [31:0] cur, input logic nxt_ok,
		input logic [31:0] nxt, input logic sec_ok, input logic [31:0] sec,
		input logic ends_run);
		int        k;
		int        i;
		out_beat_t beat;
		k = hazard_nop_count(cur, nxt_ok, nxt, sec_ok, sec);
		beat.word = cur;
		beat.nop  = 1'b0;
		beat.last = ends_run && k == 0;
		expected_beats = {expected_beats, beat};
		for (i = 1; i <= k; i++) begin
			beat.word = NopWord;
			beat.nop  = 1'b1;
			beat.last = ends_run && i == k;
			expected_beats = {expected_beats, beat};
		end
	endtask

	// window update for one accepted instruction beat
	task automatic predict_instr(input logic [31:0] w, input logic eop);
		logic [31:0] run_words [5];
		int          run_len;
		int          i;
		if (!eop) begin
			if (held_count < 2) begin
				held_words[held_count] = w;
				held_count++;
			end else begin
				push_instr_beats(held_words[0], 1'b1, held_words[1], 1'b1, w, 1'b1);
				held_words[0] = held_words[1];
				held_words[1] = w;
			end
		end else begin
			// flush: held words then the new one, missing successors never match
			for (i = 0; i < 5; i++)
				run_words[i] = '0;
			for (i = 0; i < held_count; i++)
				run_words[i] = held_words[i];
			run_words[held_count] = w;
			run_len = held_count + 1;
			for (i = 0; i < run_len; i++)
				push_instr_beats(run_words[i], i + 1 < run_len, run_words[i + 1],
					i + 2 < run_len, run_words[i + 2], i == run_len - 1);
			held_count = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// predict on instruction beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin : track
		out_beat_t want;
		if (!arst_n) begin
			expected_beats.delete();
			held_count = 0;
			pending    = 0;
			mismatches = 0;
		end else begin
			if (instr.valid && instr.ready)
				predict_instr(instr.instr_word, instr.end_of_program);
			if (result.valid && result.ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected result beat, word", result.out_word, '0);
				end else begin
					want = expected_beats.pop_front();
					if (result.out_word !== want.word)
						report_mismatch("out_word", result.out_word, want.word);
					if (result.is_inserted_nop !== want.nop)
						report_mismatch("is_inserted_nop", 32'(result.is_inserted_nop),
							32'(want.nop));
					if (result.last_of_run !== want.last)
						report_mismatch("last_of_run", 32'(result.last_of_run),
							32'(want.last));
				end
			end
			pending = expected_beats.size();
		end
	end

endmodule

@@ dv/riscv_hazard_nop_inserter_unit_test.sv @@
// riscv_hazard_nop_inserter_unit_test: stimulus, handshake idling and verdict
// for the hazard nop inserter; depends on hni_pkg, hni_if, the unit and its checker
module riscv_hazard_nop_inserter_unit_test
	import hni_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS    = 410;
	localparam int PHASE1_START   = 170;
	localparam int PHASE2_START   = 300;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   item_count = 0;
	int   idle_phase = 0;
	int   stall_cycles = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;

	hni_instr_if  instr_bus();
	hni_result_if result_bus();

	riscv_hazard_nop_inserter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_bus),
		.result (result_bus)
	);

	riscv_hazard_nop_inserter_unit_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.instr      (instr_bus),
		.result     (result_bus),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	initial begin
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int send_idle_pct();
		return (idle_phase == 0) ? 24 : (idle_phase == 1) ? 55 : 0;
	endfunction

	function automatic int recv_idle_pct();
		return (idle_phase == 0) ? 55 : (idle_phase == 1) ? 24 : 0;
	endfunction

	function automatic logic [31:0] encode(input logic [6:0] op, input logic [4:0] rd,
		input logic [4:0] rs1, input logic [4:0] rs2);
		return {7'b0, rs2, rs1, 3'b000, rd, op};
	endfunction

	// small register pool so hazards come up often
	function automatic logic [4:0] pick_reg();
		return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
	endfunction

	function automatic logic [31:0] random_instr();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(10))
			0:       w[6:0] = OpAlu;
			1:       w[6:0] = OpImm;
			2:       w[6:0] = OpSys;
			3:       w[6:0] = OpLoad;
			4:       w[6:0] = OpStore;
			5:       w[6:0] = OpBranch;
			6:       w[6:0] = OpJal;
			7:       w[6:0] = OpLui;
			8:       w[6:0] = OpAuipc;
			default: begin
			end
		endcase
		w[11:7]  = pick_reg();
		w[19:15] = pick_reg();
		w[24:20] = pick_reg();
		return w;
	endfunction

	// offer one instruction beat, valid stays high into the next offer
	task automatic offer_instr(input logic [31:0] w, input logic eop);
		while ($urandom_range(99) < send_idle_pct()) begin
			instr_bus.valid <= 1'b0;
			@(posedge clk);
		end
		instr_bus.valid          <= 1'b1;
		instr_bus.instr_word     <= w;
		instr_bus.end_of_program <= eop;
		@(posedge clk);
		while (!instr_bus.ready)
			@(posedge clk);
		item_count++;
	endtask

	task automatic drain_results();
		instr_bus.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// result ready: random stalls, one long hold-off on request
	initial begin
		result_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_bus.ready <= ($urandom_range(99) >= recv_idle_pct());
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((instr_bus.valid && instr_bus.ready) || (result_bus.valid && result_bus.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int   i;
		int   run_len;
		logic noisy;
		instr_bus.valid          <= 1'b0;
		instr_bus.instr_word     <= '0;
		instr_bus.end_of_program <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// flush of an empty window, unknown opcode with every bit set
		offer_instr(32'hFFFF_FFFF, 1'b1);
		// flush with one held word, immediate feeding alu
		offer_instr(encode(OpImm, 5'd1, 5'd0, 5'd0), 1'b0);
		offer_instr(encode(OpAlu, 5'd2, 5'd1, 5'd0), 1'b1);
		// load-use through rs2, then alu into immediate
		offer_instr(encode(OpLoad, 5'd5, 5'd0, 5'd0), 1'b0);
		offer_instr(encode(OpAlu, 5'd6, 5'd0, 5'd5), 1'b0);
		offer_instr(encode(OpImm, 5'd7, 5'd6, 5'd0), 1'b0);
		// store has an rd field but writes nothing
		offer_instr(encode(OpStore, 5'd9, 5'd7, 5'd6), 1'b0);
		offer_instr(encode(OpBranch, 5'd0, 5'd9, 5'd9), 1'b0);
		// load to x0 still counts for load-use
		offer_instr(encode(OpLoad, 5'd0, 5'd1, 5'd0), 1'b0);
		offer_instr(encode(OpAlu, 5'd0, 5'd0, 5'd0), 1'b0);
		// next word's write shadows the second successor
		offer_instr(encode(OpJal, 5'd1, 5'd0, 5'd0), 1'b0);
		offer_instr(encode(OpLui, 5'd2, 5'd0, 5'd0), 1'b0);
		offer_instr(encode(OpAlu, 5'd3, 5'd1, 5'd2), 1'b0);
		offer_instr(encode(OpAuipc, 5'd4, 5'd0, 5'd0), 1'b0);
		offer_instr(encode(OpSys, 5'd8, 5'd0, 5'd0), 1'b0);
		offer_instr(encode(OpBranch, 5'd0, 5'd4, 5'd8), 1'b0);
		offer_instr(encode(OpLoad, 5'd10, 5'd3, 5'd0), 1'b0);
		offer_instr(encode(OpStore, 5'd0, 5'd2, 5'd10), 1'b0);
		// opcode with no fields, then top registers
		offer_instr(32'h0000_0000, 1'b0);
		offer_instr(encode(OpAlu, 5'd31, 5'd31, 5'd31), 1'b0);
		offer_instr(encode(OpImm, 5'd11, 5'd31, 5'd0), 1'b0);
		offer_instr(32'hFFFF_FFB3, 1'b1);
		// chained loads: largest flush
		offer_instr(encode(OpLoad, 5'd1, 5'd1, 5'd0), 1'b0);
		offer_instr(encode(OpLoad, 5'd1, 5'd1, 5'd0), 1'b0);
		offer_instr(encode(OpLoad, 5'd1, 5'd1, 5'd0), 1'b1);

		// random sequences ending in end_of_program, some noise
		while (item_count < TOTAL_ITEMS) begin
			if (idle_phase == 0 && item_count >= PHASE1_START)
				idle_phase = 1;
			if (idle_phase == 1 && item_count >= PHASE2_START) begin
				// receiver holds off while the sender keeps offering
				idle_phase = 2;
				hold_req = 1'b1;
				for (i = 0; i < 12; i++)
					offer_instr(random_instr(), 1'b0);
				offer_instr(random_instr(), 1'b1);
				drain_results();
			end
			run_len = $urandom_range(14, 1);
			noisy = ($urandom_range(9) == 0);
			for (i = 0; i < run_len; i++) begin
				if (noisy)
					offer_instr($urandom, $urandom_range(3) == 0);
				else
					offer_instr(random_instr(), i == run_len - 1);
			end
		end
		offer_instr(random_instr(), 1'b1);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
